// ===== design/cng_pkg.sv =====
`timescale 1ns / 1ps

package cng_pkg;

	// sizing
	localparam int MAX_GRAM       = 10;
	localparam int OFFSET_BITS    = 20;
	localparam int CHAR_BYTES_W   = 3;
	localparam int GRAM_CHARS_W   = 4;
	localparam int OUT_OFF_BITS   = 20;
	localparam int OUT_LEN_BITS   = 6;
	localparam int OUT_LEN_MAX    = (1 << OUT_LEN_BITS) - 1;
	localparam int CHAR_BYTES_MAX = (1 << CHAR_BYTES_W) - 1;

	// window count holds 0..MAX_GRAM, lane index 0..MAX_GRAM-1
	localparam int CNT_BITS = $clog2(MAX_GRAM + 1);
	localparam int IDX_BITS = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
	// low position bits: enough to span a full window of longest characters
	localparam int LO_BITS  = $clog2(MAX_GRAM * CHAR_BYTES_MAX + 1);

	// queue between front and back
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = GRAM_CHARS_W;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRAM_CHARS = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EMIT_REM   = 1'b1;
	localparam logic [GRAM_CHARS_W-1:0] GRAM_CHARS_RST = 4'd2;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_SEP,
		OP_WORD
	} op_t;

	typedef struct packed {
		logic [CHAR_BYTES_W-1:0] char_bytes;
		logic                    is_word;
		logic                    doc_end;
	} char_item_t;

	typedef struct packed {
		logic [OUT_OFF_BITS-1:0] gram_offset;
		logic [OUT_LEN_BITS-1:0] gram_bytes;
		logic                    is_short;
	} gram_item_t;

	typedef struct packed {
		op_t                     op;
		logic [CHAR_BYTES_W-1:0] char_bytes;
		logic                    doc_end;
	} q_item_t;

	typedef struct packed {
		logic [GRAM_CHARS_W-1:0] gram_chars;
		logic                    emit_remainder;
	} cfg_t;

	typedef struct packed {
		logic win_empty;
		logic none_emitted;
	} bk_status_t;

endpackage

// ===== design/cng_front.sv =====
`timescale 1ns / 1ps

module cng_front import cng_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  char_item_t item,
	output q_item_t    entry
);

	logic halted_q;

	// broken data parks the rest of the document; doc end always passes
	always_comb begin
		entry.char_bytes = item.char_bytes;
		entry.doc_end    = item.doc_end;
		if (halted_q || item.char_bytes == '0) begin
			entry.op = OP_SKIP;
		end else if (item.is_word) begin
			entry.op = OP_WORD;
		end else begin
			entry.op = OP_SEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (accept) begin
			if (item.doc_end) begin
				halted_q <= 1'b0;
			end else if (item.char_bytes == '0) begin
				halted_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/cng_queue.sv =====
`timescale 1ns / 1ps

module cng_queue import cng_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    avail,
	output q_item_t pop_data
);

	q_item_t               mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] cnt_q;

	assign full     = (cnt_q == Q_CNT_BITS'(Q_DEPTH));
	assign avail    = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/cng_back.sv =====
`timescale 1ns / 1ps

module cng_back import cng_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       avail,
	input  q_item_t    entry,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output gram_item_t out_beat,
	output bk_status_t status
);

	typedef struct packed {
		logic [OFFSET_BITS-1:0] off;
		logic [LO_BITS-1:0]     lo;
	} lane_t;

	// lane 0 holds the newest character of the window
	lane_t                  lane_q [MAX_GRAM];
	logic [OFFSET_BITS-1:0] byte_pos_q;
	logic [LO_BITS-1:0]     pos_lo_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   none_q;
	logic                   out_valid_q;
	gram_item_t             out_beat_q;

	logic [CNT_BITS-1:0]    n;
	logic [CNT_BITS-1:0]    c_pre;
	logic [CNT_BITS-1:0]    c_new;
	logic [CNT_BITS-1:0]    cnt_after;
	logic [CNT_BITS-1:0]    rd_base;
	logic [IDX_BITS-1:0]    rd_idx;
	logic                   use_new;
	logic                   is_word;
	logic                   full_win;
	logic                   emit_short;
	logic                   emit;
	logic [OFFSET_BITS:0]   pos_sum;
	logic [OFFSET_BITS-1:0] byte_pos_nx;
	logic [LO_BITS-1:0]     pos_lo_nx;
	logic [LO_BITS-1:0]     span;
	lane_t                  cur_lane;
	lane_t                  old_lane;
	gram_item_t             result;

	assign pop = avail && (!out_valid_q || !out_stall);

	// clamp the gram size into 1..MAX_GRAM
	always_comb begin
		if (cfg.gram_chars == '0) begin
			n = CNT_BITS'(1);
		end else if (int'(cfg.gram_chars) > MAX_GRAM) begin
			n = CNT_BITS'(MAX_GRAM);
		end else begin
			n = CNT_BITS'(cfg.gram_chars);
		end
	end

	always_comb begin
		is_word  = (entry.op == OP_WORD);
		// a shrunken gram size drops the oldest characters first
		c_pre    = (cnt_q >= n) ? n - 1'b1 : cnt_q;
		c_new    = c_pre + 1'b1;
		full_win = is_word && (c_new == n);

		unique case (entry.op)
			OP_SKIP: cnt_after = cnt_q;
			OP_SEP:  cnt_after = '0;
			OP_WORD: cnt_after = full_win ? c_pre : c_new;
			default: cnt_after = cnt_q;
		endcase

		pos_sum = {1'b0, byte_pos_q} + (OFFSET_BITS + 1)'(entry.char_bytes);
		if (entry.op == OP_SKIP) begin
			byte_pos_nx = byte_pos_q;
			pos_lo_nx   = pos_lo_q;
		end else begin
			byte_pos_nx = pos_sum[OFFSET_BITS] ? '1 : pos_sum[OFFSET_BITS-1:0];
			pos_lo_nx   = pos_lo_q + LO_BITS'(entry.char_bytes);
		end

		// oldest character of the window being reported
		rd_base  = is_word ? c_pre : cnt_q;
		use_new  = is_word && (c_pre == '0);
		rd_idx   = (rd_base == '0) ? '0 : IDX_BITS'(rd_base - 1'b1);
		cur_lane = '{off: byte_pos_q, lo: pos_lo_q};
		old_lane = use_new ? cur_lane : lane_q[rd_idx];
		span     = pos_lo_nx - old_lane.lo;

		emit_short = entry.doc_end && cfg.emit_remainder && none_q
		             && (cnt_after != '0) && !full_win;
		emit       = full_win || emit_short;

		result.gram_offset = OUT_OFF_BITS'(old_lane.off);
		result.gram_bytes  = (int'(span) > OUT_LEN_MAX) ? '1 : OUT_LEN_BITS'(span);
		result.is_short    = !full_win;
	end

	always_ff @(posedge clk) begin
		if (pop && is_word) begin
			lane_q[0] <= cur_lane;
			for (int k = 1; k < MAX_GRAM; k++) begin
				lane_q[k] <= lane_q[k-1];
			end
		end
		if (pop && emit) begin
			out_beat_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			pos_lo_q    <= '0;
			cnt_q       <= '0;
			none_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= emit;
				if (entry.doc_end) begin
					byte_pos_q <= '0;
					pos_lo_q   <= '0;
					cnt_q      <= '0;
					none_q     <= 1'b1;
				end else begin
					byte_pos_q <= byte_pos_nx;
					pos_lo_q   <= pos_lo_nx;
					cnt_q      <= cnt_after;
					if (full_win) begin
						none_q <= 1'b0;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign out_beat            = out_beat_q;
	assign status.win_empty    = (cnt_q == '0);
	assign status.none_emitted = none_q;

endmodule

// ===== design/char_ngram_splitter.sv =====
// channel   dir  handshake                 beat
// char      in   char_valid / char_stall   char_beat : char_bytes, is_word, doc_end
// gram      out  gram_valid / gram_stall   gram_beat : gram_offset, gram_bytes, is_short
// cfg       in   cfg_we                    cfg_index, cfg_data
//
// one character beat per cycle sustained while char_stall is low; a window beat
// follows its character through the queue, then the back's output register
// the queue is two beats deep, so char_stall depends only on the queue fill
// and the back stalls on gram_stall; the front is held only once the queue is full
// arst_n clears the window, the halt flag, the queue and the registers to
// gram_chars = 2 and emit_remainder = 0; no clearing pass is needed
`timescale 1ns / 1ps

module char_ngram_splitter import cng_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     char_valid,
	output logic                     char_stall,
	input  char_item_t               char_beat,
	output logic                     gram_valid,
	input  logic                     gram_stall,
	output gram_item_t               gram_beat,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t       cfg_q;
	logic       char_accept;
	q_item_t    front_entry;
	logic       q_full;
	logic       q_avail;
	logic       q_pop;
	q_item_t    q_entry;
	bk_status_t bk_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gram_chars     <= GRAM_CHARS_RST;
			cfg_q.emit_remainder <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAM_CHARS: cfg_q.gram_chars <= cfg_data[GRAM_CHARS_W-1:0];
				REG_EMIT_REM:   cfg_q.emit_remainder <= cfg_data[0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	// front takes a beat whenever the queue has a free slot
	assign char_stall  = q_full;
	assign char_accept = char_valid && !char_stall;

	// front: classifies each character and tracks broken data
	cng_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (char_accept),
		.item   (char_beat),
		.entry  (front_entry)
	);

	// short queue decoupling classification from the window engine
	cng_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (char_accept),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_data  (q_entry)
	);

	// back: sliding window, offsets, remainder and the output register
	cng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avail     (q_avail),
		.entry     (q_entry),
		.pop       (q_pop),
		.out_valid (gram_valid),
		.out_stall (gram_stall),
		.out_beat  (gram_beat),
		.status    (bk_status)
	);

	// a new result beat only appears after the back consumed a queue entry
	a_result_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gram_valid) |-> $past(q_pop))
		else $error("result beat without a consumed entry");

	// document end leaves an empty window with nothing yet emitted
	a_doc_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.doc_end) |=> (bk_status.win_empty && bk_status.none_emitted))
		else $error("window state survived document end");

	// every reported window covers at least one byte
	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		gram_valid |-> (gram_beat.gram_bytes != '0))
		else $error("zero length window beat");

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !char_accept)
		else $error("push into full queue");

endmodule

// ===== tb/sv/char_ngram_splitter_test.sv =====
`timescale 1ns / 1ps

module char_ngram_splitter_test;
	import cng_pkg::*;

	// run guard, several times the slowest legal run
	localparam int unsigned CYCLE_LIMIT   = 200_000;
	localparam int          RANDOM_CHARS  = 600;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          REPORT_MAX    = 10;

	// receiver stall styles
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_LONG,
		STALL_PERIODIC
	} stall_style_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     char_valid = 1'b0;
	logic                     char_stall;
	char_item_t               char_beat = '0;
	logic                     gram_valid;
	logic                     gram_stall = 1'b0;
	gram_item_t               gram_beat;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	char_ngram_splitter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.gram_valid (gram_valid),
		.gram_stall (gram_stall),
		.gram_beat  (gram_beat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// window beats still owed by the block, oldest first
	gram_item_t gram_expect_q[$];

	// register shadow
	logic [GRAM_CHARS_W-1:0] cur_gram;
	logic                    cur_rem;

	// per-document window state
	logic [OFFSET_BITS-1:0]  pos_b;
	logic [OFFSET_BITS-1:0]  win_start;
	int                      win_cnt;
	int                      head;
	logic [CHAR_BYTES_W-1:0] lens [MAX_GRAM];
	bit                      none_out;
	bit                      doc_halted;

	// bookkeeping
	int unsigned cycle_count = 0;
	int          errors = 0;
	int          chars_sent = 0;
	int          live_chars = 0;
	int          grams_seen = 0;
	int          shorts_seen = 0;
	int          cfg_writes = 0;

	// idling control
	bit           gaps_on = 1'b0;
	int           burst_left = 0;
	stall_style_t stall_mode = STALL_NONE;
	int           stall_run = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs or loses a beat
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d window beats still owed",
				cycle_count, gram_expect_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stall pattern, picked per phase by stall_mode
	always @(posedge clk) begin
		case (stall_mode)
			STALL_NONE: begin
				gram_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				gram_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_LONG: begin
				// rare but long stretches of backpressure
				if (stall_run > 0) begin
					stall_run--;
					gram_stall <= 1'b1;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_run = $urandom_range(2, 12);
					gram_stall <= 1'b1;
				end else begin
					gram_stall <= 1'b0;
				end
			end
			default: begin
				gram_stall <= (cycle_count % 3 == 0);
			end
		endcase
	end

	// ---------------------------------------------------------------
	// window predictor
	// ---------------------------------------------------------------

	// byte offsets stick at the top of their range
	function automatic logic [OFFSET_BITS-1:0] add_sat(input logic [OFFSET_BITS-1:0] a,
			input logic [CHAR_BYTES_W-1:0] b);
		logic [OFFSET_BITS:0] s;
		s = a + b;
		return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
	endfunction

	// byte length of the current window, clipped to the output field
	function automatic logic [OUT_LEN_BITS-1:0] window_sum();
		int sum;
		sum = 0;
		for (int i = 0; i < win_cnt; i++)
			sum += lens[(head + i) % MAX_GRAM];
		if (sum > OUT_LEN_MAX)
			sum = OUT_LEN_MAX;
		return OUT_LEN_BITS'(sum);
	endfunction

	// slide the window start past its oldest character
	function automatic void drop_oldest();
		win_start = add_sat(win_start, lens[head]);
		head = (head + 1) % MAX_GRAM;
		win_cnt--;
	endfunction

	function automatic void clear_doc();
		pos_b = '0;
		win_start = '0;
		win_cnt = 0;
		head = 0;
		none_out = 1'b1;
		doc_halted = 1'b0;
		for (int i = 0; i < MAX_GRAM; i++)
			lens[i] = '0;
	endfunction

	// apply one accepted character beat and queue the window beat it owes
	function automatic void predict_char(input char_item_t c);
		int         n;
		bit         got;
		gram_item_t g;
		got = 1'b0;
		if (!doc_halted) begin
			live_chars++;
			if (c.char_bytes == '0) begin
				// broken data: the rest of the document is dropped
				doc_halted = 1'b1;
			end else if (!c.is_word) begin
				// separator empties the window
				pos_b = add_sat(pos_b, c.char_bytes);
				win_start = pos_b;
				win_cnt = 0;
				head = 0;
			end else begin
				// gram size 0 acts as 1, anything above MAX_GRAM as MAX_GRAM
				n = (cur_gram == '0) ? 1 : int'(cur_gram);
				if (n > MAX_GRAM)
					n = MAX_GRAM;
				// shrink first if the gram size went down mid-run
				while (win_cnt > 0 && win_cnt >= n)
					drop_oldest();
				lens[(head + win_cnt) % MAX_GRAM] = c.char_bytes;
				win_cnt++;
				pos_b = add_sat(pos_b, c.char_bytes);
				if (win_cnt == n) begin
					g.gram_offset = win_start;
					g.gram_bytes = window_sum();
					g.is_short = 1'b0;
					gram_expect_q.push_back(g);
					got = 1'b1;
					none_out = 1'b0;
					drop_oldest();
				end
			end
		end
		if (c.doc_end) begin
			// short remainder, only if nothing came out of this document
			if (!got && cur_rem && none_out && win_cnt > 0) begin
				g.gram_offset = win_start;
				g.gram_bytes = window_sum();
				g.is_short = 1'b1;
				gram_expect_q.push_back(g);
			end
			clear_doc();
		end
	endfunction

	// ---------------------------------------------------------------
	// output checker
	// ---------------------------------------------------------------

	task automatic flag_mismatch(input string what, input gram_item_t exp,
			input gram_item_t got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%s at cycle %0d: expected off=%0d len=%0d short=%0b, got off=%0d len=%0d short=%0b",
				what, cycle_count, exp.gram_offset, exp.gram_bytes, exp.is_short,
				got.gram_offset, got.gram_bytes, got.is_short);
	endtask

	always @(posedge clk) begin
		gram_item_t exp;
		if (arst_n && gram_valid && !gram_stall) begin
			grams_seen++;
			if (gram_beat.is_short)
				shorts_seen++;
			if (gram_expect_q.size() == 0) begin
				flag_mismatch("unexpected window beat", '0, gram_beat);
			end else begin
				exp = gram_expect_q.pop_front();
				if (gram_beat.gram_offset !== exp.gram_offset ||
						gram_beat.gram_bytes !== exp.gram_bytes ||
						gram_beat.is_short !== exp.is_short)
					flag_mismatch("window beat mismatch", exp, gram_beat);
			end
		end
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------

	// present one character beat and hold it until accepted; valid stays high
	// on return so back-to-back beats never drop it within a step
	task automatic send_char(input char_item_t c);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 16);
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		char_valid <= 1'b1;
		char_beat <= c;
		do
			@(posedge clk);
		while (char_stall);
		chars_sent++;
		predict_char(c);
	endtask

	task automatic feed_char(input int nbytes, input int word, input int last);
		char_item_t c;
		c.char_bytes = CHAR_BYTES_W'(nbytes);
		c.is_word = (word != 0);
		c.doc_end = (last != 0);
		send_char(c);
	endtask

	// stop sending, wait for every owed beat, then let the pipe go quiet
	task automatic drain_grams();
		char_valid <= 1'b0;
		while (gram_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back; only called with the block drained
	task automatic set_config(input int gram, input int rem);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRAM_CHARS;
		cfg_data <= CFG_DATA_BITS'(gram);
		@(posedge clk);
		cfg_index <= REG_EMIT_REM;
		cfg_data <= CFG_DATA_BITS'(rem);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_gram = GRAM_CHARS_W'(gram);
		cur_rem = (rem != 0);
		cfg_writes += 2;
	endtask

	// mostly small grams, now and then the largest and the out-of-range codes
	function automatic int pick_gram();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 4);
		if (r < 80)
			return $urandom_range(5, 9);
		if (r < 90)
			return MAX_GRAM;
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_GRAM + 1, 15);
	endfunction

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// hand-picked documents: defaults, remainder, breaks, gram changes, clipping
	task automatic test_directed();
		gaps_on = 1'b1;
		stall_mode = STALL_RANDOM;
		// reset defaults: bigrams, no remainder; odd lengths taken as-is
		feed_char(1, 1, 0);
		feed_char(4, 1, 0);
		feed_char(2, 0, 0);
		feed_char(7, 1, 0);
		feed_char(5, 1, 0);
		feed_char(3, 1, 1);
		drain_grams();
		// document too short for a full window gives the short remainder
		set_config(4, 1);
		feed_char(2, 1, 0);
		feed_char(1, 1, 0);
		feed_char(3, 1, 1);
		// break keeps the window from before it for the remainder
		feed_char(1, 1, 0);
		feed_char(0, 1, 0);
		feed_char(4, 1, 0);
		feed_char(6, 0, 1);
		drain_grams();
		// gram size shrinks mid-document, oldest characters fall out
		set_config(5, 1);
		feed_char(1, 1, 0);
		feed_char(2, 1, 0);
		feed_char(3, 1, 0);
		drain_grams();
		set_config(2, 1);
		feed_char(4, 1, 1);
		drain_grams();
		// window already past the new size goes out whole as the remainder
		set_config(MAX_GRAM, 1);
		repeat (4) feed_char(4, 1, 0);
		drain_grams();
		set_config(2, 1);
		feed_char(0, 0, 1);
		drain_grams();
		// top gram code clips to MAX_GRAM, ten 7-byte chars clip the length
		set_config(15, 0);
		for (int i = 0; i < MAX_GRAM; i++)
			feed_char(7, 1, int'(i == MAX_GRAM - 1));
		drain_grams();
		// gram code 0 behaves as unigrams
		set_config(0, 0);
		feed_char(6, 1, 0);
		feed_char(1, 1, 1);
		drain_grams();
	endtask

	// random documents: mostly well-formed words, some noise and breaks,
	// config changes between and inside documents, idling varied per document
	task automatic test_random_docs();
		int         goal;
		int         len;
		int         mid;
		int         r;
		bit         noisy;
		char_item_t c;
		goal = live_chars + RANDOM_CHARS;
		while (live_chars < goal) begin
			if ($urandom_range(0, 3) == 0) begin
				drain_grams();
				set_config(pick_gram(), int'($urandom_range(0, 1)));
			end
			gaps_on = ($urandom_range(0, 2) != 0);
			stall_mode = stall_style_t'($urandom_range(0, 3));
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
			noisy = ($urandom_range(0, 9) == 0);
			mid = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : -1;
			for (int i = 0; i < len; i++) begin
				if (i == mid) begin
					// gram size change in the middle of a document
					drain_grams();
					set_config(pick_gram(), int'($urandom_range(0, 1)));
				end
				if (noisy) begin
					c.char_bytes = CHAR_BYTES_W'($urandom_range(0, 7));
					c.is_word = 1'($urandom_range(0, 1));
					c.doc_end = ($urandom_range(0, 7) == 0);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						c.char_bytes = '0;
						c.is_word = 1'($urandom_range(0, 1));
					end else if (r < 18) begin
						c.char_bytes = CHAR_BYTES_W'($urandom_range(1, 4));
						c.is_word = 1'b0;
					end else if (r < 23) begin
						c.char_bytes = CHAR_BYTES_W'($urandom_range(5, 7));
						c.is_word = 1'($urandom_range(0, 1));
					end else begin
						c.char_bytes = CHAR_BYTES_W'($urandom_range(1, 4));
						c.is_word = 1'b1;
					end
					c.doc_end = 1'b0;
				end
				if (i == len - 1)
					c.doc_end = 1'b1;
				send_char(c);
			end
		end
		drain_grams();
	endtask

	initial begin
		cur_gram = GRAM_CHARS_RST;
		cur_rem = 1'b0;
		clear_doc();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_docs();
		drain_grams();

		$display("covered %0d char beats (%0d live) and %0d window beats (%0d short)",
			chars_sent, live_chars, grams_seen, shorts_seen);
		$display("%0d register writes, %0d mismatches, %0d cycles",
			cfg_writes, errors, cycle_count);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/cng_pkg.sv
design/cng_front.sv
design/cng_queue.sv
design/cng_back.sv
design/char_ngram_splitter.sv
tb/sv/char_ngram_splitter_test.sv
